>>> rtl/core/lss_pkg.sv
// Shared types, constants and helpers of the literal substring search block.
`default_nettype none

package lss_pkg;

    localparam int MAX_NEEDLE = 32;
    localparam int NEEDLE_W   = 8 * MAX_NEEDLE;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 13;
    localparam int LINE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [POS_W-1:0]  LINE_BYTES    = 13'd4096;
    localparam logic [LINE_W-1:0] LINE_CAP      = 16'hFFFF;
    localparam logic [CNT_W-1:0]  HIT_LIMIT_RST = 16'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CASE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT  = 3'd6;

    typedef struct packed {
        logic       start_search;
        logic       has_byte;
        logic [7:0] text_byte;
        logic       line_done;
    } t_in_word;

    typedef struct packed {
        logic [LINE_W-1:0] hit_line;
        logic [POS_W-1:0]  hit_begin;
        logic [POS_W-1:0]  hit_end;
        logic              limit_reached;
    } t_out_word;

    typedef struct packed {
        logic [NEEDLE_W-1:0] needle;
        logic [LEN_W-1:0]    needle_length;
        logic                match_case;
        logic [CNT_W-1:0]    hit_limit;
    } t_cfg;

    // ASCII fold to lower case unless exact matching is selected
    function automatic logic [7:0] fold(input logic [7:0] b, input logic exact);
        logic [7:0] r;
        r = b;
        if (!exact && b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lss_cfg.sv
// Configuration register file: needle, length, case mode and hit limit.
`default_nettype none

module lss_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr,
    input  wire logic [lss_pkg::CFG_IDX_W-1:0]    i_idx,
    input  wire logic [lss_pkg::CFG_DATA_W-1:0]   i_data,
    output lss_pkg::t_cfg                         o_cfg
);

    lss_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.needle        <= '0;
            r_cfg.needle_length <= '0;
            r_cfg.match_case    <= 1'b1;
            r_cfg.hit_limit     <= lss_pkg::HIT_LIMIT_RST;
        end else if (i_wr) begin
            case (i_idx)
                lss_pkg::CFG_NEEDLE_0:   r_cfg.needle[0*64 +: 64] <= i_data;
                lss_pkg::CFG_NEEDLE_1:   r_cfg.needle[1*64 +: 64] <= i_data;
                lss_pkg::CFG_NEEDLE_2:   r_cfg.needle[2*64 +: 64] <= i_data;
                lss_pkg::CFG_NEEDLE_3:   r_cfg.needle[3*64 +: 64] <= i_data;
                lss_pkg::CFG_NEEDLE_LEN: r_cfg.needle_length <= i_data[lss_pkg::LEN_W-1:0];
                lss_pkg::CFG_MATCH_CASE: r_cfg.match_case <= i_data[0];
                lss_pkg::CFG_HIT_LIMIT:  r_cfg.hit_limit <= i_data[lss_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/lss_match.sv
// Byte window, state and parallel needle compare, one word per cycle on i_adv.
`default_nettype none

module lss_match (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  lss_pkg::t_in_word      i_word,
    input  lss_pkg::t_cfg          i_cfg,
    output logic                   o_hit,
    output lss_pkg::t_out_word     o_res
);

    localparam int N = lss_pkg::MAX_NEEDLE;

    logic [7:0]                  r_win [N];
    logic [lss_pkg::POS_W-1:0]   r_pos;
    logic [lss_pkg::POS_W-1:0]   r_nas;
    logic [lss_pkg::LINE_W-1:0]  r_line;
    logic [lss_pkg::CNT_W-1:0]   r_hits;

    logic [7:0]                  cur_win [N];
    logic [7:0]                  new_win [N];
    logic [7:0]                  n_win   [N];
    logic [lss_pkg::POS_W-1:0]   cur_pos, cur_nas, pos_inc, len_ext, hit_begin;
    logic [lss_pkg::POS_W-1:0]   n_pos, n_nas;
    logic [lss_pkg::LINE_W-1:0]  cur_line, n_line;
    logic [lss_pkg::CNT_W-1:0]   cur_hits, hits_inc, n_hits;
    logic [lss_pkg::NEEDLE_W-1:0] rev, pat;
    logic [lss_pkg::LEN_W-1:0]   shamt;
    logic [N-1:0]                eq;
    logic                        take, len_ok, hit;

    // needle reversed so that byte 0 of the aligned pattern is the last needle byte
    always_comb begin
        for (int j = 0; j < N; j++) begin
            rev[8*j +: 8] = lss_pkg::fold(i_cfg.needle[8*(N-1-j) +: 8], i_cfg.match_case);
        end
        shamt = lss_pkg::LEN_W'(N) - i_cfg.needle_length;
        pat   = rev >> {shamt, 3'b000};
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            cur_win[j] = i_word.start_search ? 8'h00 : r_win[j];
        end
        cur_pos  = i_word.start_search ? '0 : r_pos;
        cur_nas  = i_word.start_search ? '0 : r_nas;
        cur_line = i_word.start_search ? '0 : r_line;
        cur_hits = i_word.start_search ? '0 : r_hits;

        take    = i_word.has_byte && (cur_pos < lss_pkg::LINE_BYTES);
        pos_inc = cur_pos + 1'b1;

        new_win[0] = lss_pkg::fold(i_word.text_byte, i_cfg.match_case);
        for (int j = 1; j < N; j++) begin
            new_win[j] = cur_win[j-1];
        end

        for (int j = 0; j < N; j++) begin
            eq[j] = (lss_pkg::LEN_W'(j) >= i_cfg.needle_length)
                    || (new_win[j] == pat[8*j +: 8]);
        end

        len_ext   = {{(lss_pkg::POS_W-lss_pkg::LEN_W){1'b0}}, i_cfg.needle_length};
        hit_begin = pos_inc - len_ext;
        len_ok    = (i_cfg.needle_length != '0)
                    && (i_cfg.needle_length <= lss_pkg::LEN_W'(N));
        hit       = take && len_ok && (pos_inc >= len_ext) && (hit_begin >= cur_nas)
                    && (cur_hits < i_cfg.hit_limit) && (&eq);
        hits_inc  = cur_hits + 1'b1;

        for (int j = 0; j < N; j++) begin
            n_win[j] = take ? new_win[j] : cur_win[j];
        end
        n_pos  = take ? pos_inc : cur_pos;
        n_nas  = hit ? pos_inc : cur_nas;
        n_hits = hit ? hits_inc : cur_hits;
        n_line = cur_line;
        if (i_word.line_done) begin
            n_pos = '0;
            n_nas = '0;
            if (cur_line != lss_pkg::LINE_CAP) begin
                n_line = cur_line + 1'b1;
            end
        end

        o_hit                = hit;
        o_res.hit_line       = cur_line;
        o_res.hit_begin      = hit_begin;
        o_res.hit_end        = pos_inc;
        o_res.limit_reached  = (hits_inc == i_cfg.hit_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_win[j] <= 8'h00;
            end
            r_pos  <= '0;
            r_nas  <= '0;
            r_line <= '0;
            r_hits <= '0;
        end else if (i_adv) begin
            for (int j = 0; j < N; j++) begin
                r_win[j] <= n_win[j];
            end
            r_pos  <= n_pos;
            r_nas  <= n_nas;
            r_line <= n_line;
            r_hits <= n_hits;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/literal_substring_search.sv
// Top level: streaming literal substring search with input and result registers.
//
//  channel | valid       | ready       | word / data
//  --------+-------------+-------------+------------------------------------
//  text in | i_in_valid  | o_in_ready  | i_in_word  (lss_pkg::t_in_word)
//  hits    | o_out_valid | i_out_ready | o_out_word (lss_pkg::t_out_word)
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data (64 bit)
//
// One word per cycle unless a hit stalls: compare and state update run straight off
// the input register, and a hit goes from there into the result register.
// Reset (synchronous, active low) clears window, counters and both stage valids
// and loads the register defaults (match_case 1, hit_limit 1024).
// A hit waiting on i_out_ready holds the compare stage; the input register
// still takes one more word, then o_in_ready stays low until the hit drains.
`default_nettype none

module literal_substring_search (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  lss_pkg::t_in_word                   i_in_word,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output lss_pkg::t_out_word                  o_out_word,

    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lss_pkg::t_cfg      cfg;
    lss_pkg::t_in_word  r_in;
    logic               r_in_vld;
    lss_pkg::t_out_word r_out;
    logic               r_out_vld;
    lss_pkg::t_out_word res;
    logic               hit;
    logic               adv;

    // register writes never stall
    assign o_cfg_ready = 1'b1;

    lss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // compare stage moves when the result register is free or draining
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    lss_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_hit   (hit),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_word;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= hit;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && hit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/lss_chk.sv
// Port-level checker for the literal substring search top level, with bind.
`default_nettype none

module lss_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input lss_pkg::t_out_word      o_out_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("hit word dropped or changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.hit_end > o_out_word.hit_begin)
        else $error("hit range empty or reversed");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.hit_end <= lss_pkg::LINE_BYTES)
        else $error("hit end beyond line limit");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("hit valid right after reset");

endmodule

bind literal_substring_search lss_chk u_lss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
